// ----- rtl/rabin_pkg.sv -----
// Shared types, constants, modular helpers and the sequencer program of the Rabin block.
package rabin_pkg;

  localparam int unsigned DataW        = 64;
  localparam int unsigned PrimeBitsDef = 32;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned PcW          = 7;

  // Datapath and sequencer operations.
  typedef enum logic [4:0] {
    OP_MOD,
    OP_SMODP,
    OP_SMODQ,
    OP_GSTEP,
    OP_MULM,
    OP_ADDM,
    OP_SUBM,
    OP_HALF,
    OP_MULPQ,
    OP_LDE,
    OP_SHE,
    OP_GINIT,
    OP_EMIT,
    OP_BR_KZ,
    OP_BR_PQZ,
    OP_BR_EZ,
    OP_BR_EL0,
    OP_BR_GZ,
    OP_JMP
  } op_e;

  // Operand sources.
  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_FOUR,
    SRC_DATA,
    SRC_OFFB,
    SRC_KEY,
    SRC_P,
    SRC_Q,
    SRC_R0,
    SRC_R1,
    SRC_R2,
    SRC_R3,
    SRC_R4,
    SRC_R5,
    SRC_R6,
    SRC_R7
  } src_e;

  // Scratch register destinations.
  typedef enum logic [2:0] {
    RG_0, RG_1, RG_2, RG_3, RG_4, RG_5, RG_6, RG_7
  } reg_e;

  typedef struct packed {
    op_e            op;
    reg_e           dst;
    src_e           sa;
    src_e           sb;
    src_e           sm;
    logic [PcW-1:0] tgt;
    logic [1:0]     idx;
    logic           last;
  } instr_t;

  typedef struct packed {
    logic   valid;
    logic   load;
    instr_t ins;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic key_zero;
    logic pq_zero;
    logic e_zero;
    logic e_lsb;
    logic g_zero;
  } dp_stat_t;

  // Program labels.
  localparam logic [PcW-1:0] PcEnc   = 7'd0;
  localparam logic [PcW-1:0] PcEncZ  = 7'd6;
  localparam logic [PcW-1:0] PcDec   = 7'd7;
  localparam logic [PcW-1:0] PcPLoop = 7'd18;
  localparam logic [PcW-1:0] PcPMul  = 7'd21;
  localparam logic [PcW-1:0] PcPEnd  = 7'd24;
  localparam logic [PcW-1:0] PcQLoop = 7'd27;
  localparam logic [PcW-1:0] PcQMul  = 7'd30;
  localparam logic [PcW-1:0] PcQEnd  = 7'd33;
  localparam logic [PcW-1:0] PcGLoop = 7'd34;
  localparam logic [PcW-1:0] PcGEnd  = 7'd37;
  localparam logic [PcW-1:0] PcDecZ  = 7'd61;

  // (a + b) mod m for a, b below m.
  function automatic logic [DataW-1:0] add_mod(input logic [DataW-1:0] a,
                                               input logic [DataW-1:0] b,
                                               input logic [DataW-1:0] m);
    logic [DataW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[DataW-1:0];
  endfunction

  // (a - b) mod m for a, b below m.
  function automatic logic [DataW-1:0] sub_mod(input logic [DataW-1:0] a,
                                               input logic [DataW-1:0] b,
                                               input logic [DataW-1:0] m);
    logic [DataW-1:0] d;
    d = a - b;
    if (a < b) begin
      d = d + m;
    end
    return d;
  endfunction

  function automatic instr_t dop(input op_e op, input reg_e dst, input src_e sa,
                                 input src_e sb, input src_e sm);
    instr_t i;
    i.op   = op;
    i.dst  = dst;
    i.sa   = sa;
    i.sb   = sb;
    i.sm   = sm;
    i.tgt  = '0;
    i.idx  = '0;
    i.last = 1'b0;
    return i;
  endfunction

  function automatic instr_t br(input op_e op, input logic [PcW-1:0] tgt);
    instr_t i;
    i     = dop(op, RG_0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
    i.tgt = tgt;
    return i;
  endfunction

  function automatic instr_t emit(input src_e s, input logic [1:0] idx, input logic last);
    instr_t i;
    i      = dop(OP_EMIT, RG_0, s, SRC_ZERO, SRC_ZERO);
    i.idx  = idx;
    i.last = last;
    return i;
  endfunction

  // Sequencer program. Encrypt starts at PcEnc, decrypt at PcDec.
  function automatic instr_t ucode(input logic [PcW-1:0] pc);
    instr_t i;
    case (pc)
      // Encrypt: c = m * (m + b) mod n.
      7'd0:  i = br(OP_BR_KZ, PcEncZ);
      7'd1:  i = dop(OP_MOD,  RG_0, SRC_DATA, SRC_ZERO, SRC_KEY);
      7'd2:  i = dop(OP_MOD,  RG_1, SRC_OFFB, SRC_ZERO, SRC_KEY);
      7'd3:  i = dop(OP_ADDM, RG_1, SRC_R0, SRC_R1, SRC_KEY);
      7'd4:  i = dop(OP_MULM, RG_2, SRC_R0, SRC_R1, SRC_KEY);
      7'd5:  i = emit(SRC_R2, 2'd0, 1'b1);
      7'd6:  i = emit(SRC_ZERO, 2'd0, 1'b1);
      // Decrypt: N, b mod N and D = 4c + b^2 mod N.
      7'd7:  i = br(OP_BR_PQZ, PcDecZ);
      7'd8:  i = dop(OP_MULPQ, RG_7, SRC_P, SRC_Q, SRC_ZERO);
      7'd9:  i = dop(OP_MOD,  RG_6, SRC_OFFB, SRC_ZERO, SRC_R7);
      7'd10: i = dop(OP_MOD,  RG_0, SRC_FOUR, SRC_ZERO, SRC_R7);
      7'd11: i = dop(OP_MOD,  RG_1, SRC_DATA, SRC_ZERO, SRC_R7);
      7'd12: i = dop(OP_MULM, RG_0, SRC_R0, SRC_R1, SRC_R7);
      7'd13: i = dop(OP_MULM, RG_1, SRC_R6, SRC_R6, SRC_R7);
      7'd14: i = dop(OP_ADDM, RG_0, SRC_R0, SRC_R1, SRC_R7);
      // Root mod p by square and multiply.
      7'd15: i = dop(OP_MOD,  RG_1, SRC_R0, SRC_ZERO, SRC_P);
      7'd16: i = dop(OP_MOD,  RG_2, SRC_ONE, SRC_ZERO, SRC_P);
      7'd17: i = dop(OP_LDE,  RG_0, SRC_P, SRC_ZERO, SRC_ZERO);
      7'd18: i = br(OP_BR_EZ, PcPEnd);
      7'd19: i = br(OP_BR_EL0, PcPMul);
      7'd20: i = dop(OP_MULM, RG_2, SRC_R2, SRC_R1, SRC_P);
      7'd21: i = dop(OP_MULM, RG_1, SRC_R1, SRC_R1, SRC_P);
      7'd22: i = dop(OP_SHE,  RG_0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
      7'd23: i = br(OP_JMP, PcPLoop);
      // Root mod q.
      7'd24: i = dop(OP_MOD,  RG_3, SRC_R0, SRC_ZERO, SRC_Q);
      7'd25: i = dop(OP_MOD,  RG_4, SRC_ONE, SRC_ZERO, SRC_Q);
      7'd26: i = dop(OP_LDE,  RG_0, SRC_Q, SRC_ZERO, SRC_ZERO);
      7'd27: i = br(OP_BR_EZ, PcQEnd);
      7'd28: i = br(OP_BR_EL0, PcQMul);
      7'd29: i = dop(OP_MULM, RG_4, SRC_R4, SRC_R3, SRC_Q);
      7'd30: i = dop(OP_MULM, RG_3, SRC_R3, SRC_R3, SRC_Q);
      7'd31: i = dop(OP_SHE,  RG_0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
      7'd32: i = br(OP_JMP, PcQLoop);
      // Extended Euclid on p and q.
      7'd33: i = dop(OP_GINIT, RG_0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
      7'd34: i = br(OP_BR_GZ, PcGEnd);
      7'd35: i = dop(OP_GSTEP, RG_0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
      7'd36: i = br(OP_JMP, PcGLoop);
      // CRT coefficients and the two cross terms.
      7'd37: i = dop(OP_SMODP, RG_1, SRC_ZERO, SRC_ZERO, SRC_R7);
      7'd38: i = dop(OP_MOD,  RG_5, SRC_P, SRC_ZERO, SRC_R7);
      7'd39: i = dop(OP_MULM, RG_1, SRC_R1, SRC_R5, SRC_R7);
      7'd40: i = dop(OP_SMODQ, RG_0, SRC_ZERO, SRC_ZERO, SRC_R7);
      7'd41: i = dop(OP_MOD,  RG_5, SRC_Q, SRC_ZERO, SRC_R7);
      7'd42: i = dop(OP_MULM, RG_0, SRC_R0, SRC_R5, SRC_R7);
      7'd43: i = dop(OP_MULM, RG_1, SRC_R1, SRC_R4, SRC_R7);
      7'd44: i = dop(OP_MULM, RG_0, SRC_R0, SRC_R2, SRC_R7);
      7'd45: i = dop(OP_ADDM, RG_2, SRC_R1, SRC_R0, SRC_R7);
      7'd46: i = dop(OP_SUBM, RG_3, SRC_R1, SRC_R0, SRC_R7);
      // Four candidates (x - b) / 2 mod N.
      7'd47: i = dop(OP_SUBM, RG_4, SRC_R2, SRC_R6, SRC_R7);
      7'd48: i = dop(OP_HALF, RG_4, SRC_R4, SRC_ZERO, SRC_R7);
      7'd49: i = emit(SRC_R4, 2'd0, 1'b0);
      7'd50: i = dop(OP_SUBM, RG_5, SRC_ZERO, SRC_R2, SRC_R7);
      7'd51: i = dop(OP_SUBM, RG_5, SRC_R5, SRC_R6, SRC_R7);
      7'd52: i = dop(OP_HALF, RG_5, SRC_R5, SRC_ZERO, SRC_R7);
      7'd53: i = emit(SRC_R5, 2'd1, 1'b0);
      7'd54: i = dop(OP_SUBM, RG_4, SRC_R3, SRC_R6, SRC_R7);
      7'd55: i = dop(OP_HALF, RG_4, SRC_R4, SRC_ZERO, SRC_R7);
      7'd56: i = emit(SRC_R4, 2'd2, 1'b0);
      7'd57: i = dop(OP_SUBM, RG_5, SRC_ZERO, SRC_R3, SRC_R7);
      7'd58: i = dop(OP_SUBM, RG_5, SRC_R5, SRC_R6, SRC_R7);
      7'd59: i = dop(OP_HALF, RG_5, SRC_R5, SRC_ZERO, SRC_R7);
      7'd60: i = emit(SRC_R5, 2'd3, 1'b1);
      // Zero prime: four zero candidates.
      7'd61: i = emit(SRC_ZERO, 2'd0, 1'b0);
      7'd62: i = emit(SRC_ZERO, 2'd1, 1'b0);
      7'd63: i = emit(SRC_ZERO, 2'd2, 1'b0);
      7'd64: i = emit(SRC_ZERO, 2'd3, 1'b1);
      default: i = emit(SRC_ZERO, 2'd0, 1'b1);
    endcase
    return i;
  endfunction

endpackage

// ----- rtl/rabin_ctrl.sv -----
// Sequencer that steps the Rabin program and drives the datapath commands.
module rabin_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                opcode_i,
  output logic                in_ready_o,
  output rabin_pkg::dp_cmd_t  cmd_o,
  input  rabin_pkg::dp_stat_t stat_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic                      state_q, state_d;
  logic [rabin_pkg::PcW-1:0] pc_q, pc_d;
  rabin_pkg::instr_t         instr;
  logic [rabin_pkg::PcW-1:0] pc_inc;

  assign instr  = rabin_pkg::ucode(pc_q);
  assign pc_inc = pc_q + 1'b1;

  // Next state, program counter and command.
  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    in_ready_o   = 1'b0;
    cmd_o.valid  = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.ins    = instr;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pc_d       = opcode_i ? rabin_pkg::PcDec : rabin_pkg::PcEnc;
          state_d    = StExec;
        end
      end
      StExec: begin
        unique case (instr.op)
          rabin_pkg::OP_BR_KZ:  pc_d = stat_i.key_zero ? instr.tgt : pc_inc;
          rabin_pkg::OP_BR_PQZ: pc_d = stat_i.pq_zero ? instr.tgt : pc_inc;
          rabin_pkg::OP_BR_EZ:  pc_d = stat_i.e_zero ? instr.tgt : pc_inc;
          rabin_pkg::OP_BR_EL0: pc_d = stat_i.e_lsb ? pc_inc : instr.tgt;
          rabin_pkg::OP_BR_GZ:  pc_d = stat_i.g_zero ? instr.tgt : pc_inc;
          rabin_pkg::OP_JMP:    pc_d = instr.tgt;
          default: begin
            cmd_o.valid = 1'b1;
            if (stat_i.done) begin
              pc_d = pc_inc;
              if (instr.op == rabin_pkg::OP_EMIT && instr.last) begin
                state_d = StIdle;
              end
            end
          end
        endcase
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pc_q    <= rabin_pkg::PcEnc;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

endmodule

// ----- rtl/rabin_dp.sv -----
// Datapath: key registers, scratch registers, shared modular multiplier and divider, output stage.
module rabin_dp #(
  parameter int unsigned PRIME_BITS = rabin_pkg::PrimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rabin_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rabin_pkg::DataW-1:0]   cfg_data_i,
  input  logic [rabin_pkg::DataW-1:0]   data_in_i,
  input  rabin_pkg::dp_cmd_t            cmd_i,
  output rabin_pkg::dp_stat_t           stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [rabin_pkg::DataW-1:0]   value_out_o,
  output logic [1:0]                    candidate_index_o,
  output logic                          last_o
);

  localparam int unsigned DW   = rabin_pkg::DataW;
  localparam int unsigned PB   = PRIME_BITS;
  localparam int unsigned CW   = PRIME_BITS + 2;
  localparam int unsigned CntW = $clog2(DW);
  localparam logic [CntW-1:0] CntLast = CntW'(DW - 1);

  localparam logic [rabin_pkg::CfgIdxW-1:0] CfgP   = 2'd0;
  localparam logic [rabin_pkg::CfgIdxW-1:0] CfgQ   = 2'd1;
  localparam logic [rabin_pkg::CfgIdxW-1:0] CfgKey = 2'd2;
  localparam logic [rabin_pkg::CfgIdxW-1:0] CfgOff = 2'd3;

  // Key registers.
  logic [PB-1:0] prime_p_q, prime_q_q;
  logic [DW-1:0] key_q, offb_q;

  // Item and scratch registers.
  logic [DW-1:0] data_q;
  logic [DW-1:0] r0_q, r1_q, r2_q, r3_q, r4_q, r5_q, r6_q, r7_q;
  logic [PB-1:0] e_q, e_d;

  // Extended Euclid state.
  logic [PB-1:0]        ga_q, ga_d, gb_q, gb_d;
  logic signed [CW-1:0] sa_q, sa_d, sb_q, sb_d, ta_q, ta_d, tb_q, tb_d;

  // Shared iterative unit.
  logic [DW-1:0]   acc_q, acc_d, sh_q, sh_d, opa_q, opa_d, opm_q, opm_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, neg_q, neg_d;

  // Output stage.
  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] out_val_q, out_val_d;
  logic [1:0]    out_idx_q, out_idx_d;
  logic          out_last_q, out_last_d;

  logic [DW-1:0]   a_v, b_v, m_v;
  logic [DW-1:0]   mul_r1, mul_acc, div_acc, div_sh, step_acc, step_sh;
  logic [DW:0]     div_t, div_diff;
  logic            div_ge, last_step, wr_en, out_free, dp_done;
  logic [DW-1:0]   wr_data, half_v;
  logic [PB-1:0]   qv;
  logic [CW-1:0]   sb_abs, tb_abs;
  logic signed [PB+CW:0] prod_a, prod_t;
  rabin_pkg::op_e  op;

  function automatic logic [DW-1:0] rd(input rabin_pkg::src_e s);
    logic [DW-1:0] v;
    unique case (s)
      rabin_pkg::SRC_ZERO: v = '0;
      rabin_pkg::SRC_ONE:  v = DW'(1);
      rabin_pkg::SRC_FOUR: v = DW'(4);
      rabin_pkg::SRC_DATA: v = data_q;
      rabin_pkg::SRC_OFFB: v = offb_q;
      rabin_pkg::SRC_KEY:  v = key_q;
      rabin_pkg::SRC_P:    v = DW'(prime_p_q);
      rabin_pkg::SRC_Q:    v = DW'(prime_q_q);
      rabin_pkg::SRC_R0:   v = r0_q;
      rabin_pkg::SRC_R1:   v = r1_q;
      rabin_pkg::SRC_R2:   v = r2_q;
      rabin_pkg::SRC_R3:   v = r3_q;
      rabin_pkg::SRC_R4:   v = r4_q;
      rabin_pkg::SRC_R5:   v = r5_q;
      rabin_pkg::SRC_R6:   v = r6_q;
      rabin_pkg::SRC_R7:   v = r7_q;
      default:             v = '0;
    endcase
    return v;
  endfunction

  assign op  = cmd_i.ins.op;
  assign a_v = rd(cmd_i.ins.sa);
  assign b_v = rd(cmd_i.ins.sb);
  assign m_v = rd(cmd_i.ins.sm);

  // One multiply step: double, then add the multiplicand on a set bit.
  assign mul_r1  = rabin_pkg::add_mod(acc_q, acc_q, opm_q);
  assign mul_acc = sh_q[DW-1] ? rabin_pkg::add_mod(mul_r1, opa_q, opm_q) : mul_r1;

  // One restoring division step.
  assign div_t    = {acc_q, sh_q[DW-1]};
  assign div_diff = div_t - {1'b0, opm_q};
  assign div_ge   = (div_t >= {1'b0, opm_q});
  assign div_acc  = div_ge ? div_diff[DW-1:0] : div_t[DW-1:0];
  assign div_sh   = {sh_q[DW-2:0], div_ge};

  assign step_acc  = (op == rabin_pkg::OP_MULM) ? mul_acc : div_acc;
  assign step_sh   = (op == rabin_pkg::OP_MULM) ? {sh_q[DW-2:0], 1'b0} : div_sh;
  assign last_step = busy_q && (cnt_q == CntLast);
  assign out_free  = !out_valid_q || out_ready_i;

  // Halving mod N: an odd value takes floor((v + N) / 2).
  assign half_v = a_v[0] ? ((a_v >> 1) + (m_v >> 1) + DW'(m_v[0])) : (a_v >> 1);

  // Euclid quotient and coefficient products.
  assign qv     = step_sh[PB-1:0];
  assign prod_a = $signed({1'b0, qv}) * sa_q;
  assign prod_t = $signed({1'b0, qv}) * ta_q;
  assign sb_abs = sb_q[CW-1] ? (CW'(0) - sb_q) : sb_q;
  assign tb_abs = tb_q[CW-1] ? (CW'(0) - tb_q) : tb_q;

  // Command execution.
  always_comb begin
    acc_d       = acc_q;
    sh_d        = sh_q;
    opa_d       = opa_q;
    opm_d       = opm_q;
    cnt_d       = cnt_q;
    busy_d      = busy_q;
    neg_d       = neg_q;
    e_d         = e_q;
    ga_d        = ga_q;
    gb_d        = gb_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    ta_d        = ta_q;
    tb_d        = tb_q;
    wr_en       = 1'b0;
    wr_data     = step_acc;
    dp_done     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;

    if (busy_q) begin
      acc_d = step_acc;
      sh_d  = step_sh;
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d  = 1'b0;
        dp_done = 1'b1;
        case (op)
          rabin_pkg::OP_GSTEP: begin
            ga_d = step_acc[PB-1:0];
            gb_d = ga_q;
            sa_d = sb_q - CW'(prod_a);
            sb_d = sa_q;
            ta_d = tb_q - CW'(prod_t);
            tb_d = ta_q;
          end
          rabin_pkg::OP_SMODP, rabin_pkg::OP_SMODQ: begin
            wr_en   = 1'b1;
            wr_data = (neg_q && step_acc != '0) ? (opm_q - step_acc) : step_acc;
          end
          default: wr_en = 1'b1;
        endcase
      end
    end else if (cmd_i.valid) begin
      case (op)
        rabin_pkg::OP_MOD: begin
          busy_d = 1'b1;
          cnt_d  = '0;
          acc_d  = '0;
          sh_d   = a_v;
          opm_d  = m_v;
        end
        rabin_pkg::OP_SMODP: begin
          busy_d = 1'b1;
          cnt_d  = '0;
          acc_d  = '0;
          sh_d   = DW'(sb_abs);
          opm_d  = m_v;
          neg_d  = sb_q[CW-1];
        end
        rabin_pkg::OP_SMODQ: begin
          busy_d = 1'b1;
          cnt_d  = '0;
          acc_d  = '0;
          sh_d   = DW'(tb_abs);
          opm_d  = m_v;
          neg_d  = tb_q[CW-1];
        end
        rabin_pkg::OP_GSTEP: begin
          busy_d = 1'b1;
          cnt_d  = '0;
          acc_d  = '0;
          sh_d   = DW'(gb_q);
          opm_d  = DW'(ga_q);
        end
        rabin_pkg::OP_MULM: begin
          busy_d = 1'b1;
          cnt_d  = '0;
          acc_d  = '0;
          sh_d   = b_v;
          opa_d  = a_v;
          opm_d  = m_v;
        end
        rabin_pkg::OP_ADDM: begin
          dp_done = 1'b1;
          wr_en   = 1'b1;
          wr_data = rabin_pkg::add_mod(a_v, b_v, m_v);
        end
        rabin_pkg::OP_SUBM: begin
          dp_done = 1'b1;
          wr_en   = 1'b1;
          wr_data = rabin_pkg::sub_mod(a_v, b_v, m_v);
        end
        rabin_pkg::OP_HALF: begin
          dp_done = 1'b1;
          wr_en   = 1'b1;
          wr_data = half_v;
        end
        rabin_pkg::OP_MULPQ: begin
          dp_done = 1'b1;
          wr_en   = 1'b1;
          wr_data = DW'(a_v[PB-1:0]) * DW'(b_v[PB-1:0]);
        end
        rabin_pkg::OP_LDE: begin
          dp_done = 1'b1;
          e_d     = PB'(({1'b0, a_v[PB-1:0]} + 1'b1) >> 2);
        end
        rabin_pkg::OP_SHE: begin
          dp_done = 1'b1;
          e_d     = e_q >> 1;
        end
        rabin_pkg::OP_GINIT: begin
          dp_done = 1'b1;
          ga_d    = prime_p_q;
          gb_d    = prime_q_q;
          sa_d    = CW'(1);
          ta_d    = '0;
          sb_d    = '0;
          tb_d    = CW'(1);
        end
        rabin_pkg::OP_EMIT: begin
          dp_done = out_free;
          if (out_free) begin
            out_valid_d = 1'b1;
            out_val_d   = a_v;
            out_idx_d   = cmd_i.ins.idx;
            out_last_d  = cmd_i.ins.last;
          end
        end
        default: dp_done = 1'b1;
      endcase
    end
  end

  assign stat_o.done     = dp_done;
  assign stat_o.key_zero = (key_q == '0);
  assign stat_o.pq_zero  = (prime_p_q == '0) || (prime_q_q == '0);
  assign stat_o.e_zero   = (e_q == '0);
  assign stat_o.e_lsb    = e_q[0];
  assign stat_o.g_zero   = (ga_q == '0);

  // Key registers written from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_p_q <= PB'(3);
      prime_q_q <= PB'(7);
      key_q     <= DW'(21);
      offb_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgP:   prime_p_q <= cfg_data_i[PB-1:0];
        CfgQ:   prime_q_q <= cfg_data_i[PB-1:0];
        CfgKey: key_q     <= cfg_data_i;
        CfgOff: offb_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state of the iterative unit and output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    sh_q       <= sh_d;
    opa_q      <= opa_d;
    opm_q      <= opm_d;
    neg_q      <= neg_d;
    e_q        <= e_d;
    ga_q       <= ga_d;
    gb_q       <= gb_d;
    sa_q       <= sa_d;
    sb_q       <= sb_d;
    ta_q       <= ta_d;
    tb_q       <= tb_d;
    out_val_q  <= out_val_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
    if (cmd_i.load) begin
      data_q <= data_in_i;
    end
    if (wr_en) begin
      case (cmd_i.ins.dst)
        rabin_pkg::RG_0: r0_q <= wr_data;
        rabin_pkg::RG_1: r1_q <= wr_data;
        rabin_pkg::RG_2: r2_q <= wr_data;
        rabin_pkg::RG_3: r3_q <= wr_data;
        rabin_pkg::RG_4: r4_q <= wr_data;
        rabin_pkg::RG_5: r5_q <= wr_data;
        rabin_pkg::RG_6: r6_q <= wr_data;
        rabin_pkg::RG_7: r7_q <= wr_data;
        default: ;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign value_out_o       = out_val_q;
  assign candidate_index_o = out_idx_q;
  assign last_o            = out_last_q;

endmodule

// ----- rtl/rabin_encrypt_decrypt.sv -----
// Top level of the Rabin encrypt and decrypt block with offset b.
//
//   Channel   Direction  Handshake                   Payload
//   input     in         in_valid_i / in_ready_o     opcode_i, data_in_i
//   output    out        out_valid_o / out_ready_i   value_out_o, candidate_index_o, last_o
//   config    in         cfg_we_i (no wait)          cfg_index_i, cfg_data_i
//
// One transaction is worked at a time by a sequencer over a shared 64-bit unit that does
// one modular multiply or divide bit per cycle.
// Decrypt is dominated by the two square-and-multiply exponentiations and the Euclid loop
// on that unit. A zero prime or zero modulus skips the arithmetic and emits zero results.
// Reset loads the key registers with p = 3, q = 7, n = 21, b = 0; no clearing pass.
// A waiting result does not stall a new input transaction; a new result waits for the
// output register to empty.
module rabin_encrypt_decrypt #(
  parameter int unsigned PRIME_BITS = rabin_pkg::PrimeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rabin_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rabin_pkg::DataW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [rabin_pkg::DataW-1:0]   data_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rabin_pkg::DataW-1:0]   value_out_o,
  output logic [1:0]                    candidate_index_o,
  output logic                          last_o
);

  rabin_pkg::dp_cmd_t  cmd;
  rabin_pkg::dp_stat_t stat;

  // Sequencer.
  rabin_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // Datapath.
  rabin_dp #(
    .PRIME_BITS (PRIME_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .data_in_i         (data_in_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .value_out_o       (value_out_o),
    .candidate_index_o (candidate_index_o),
    .last_o            (last_o)
  );

endmodule

// ----- sim/tb_rabin_encrypt_decrypt.sv -----
// Self-checking testbench for the Rabin encrypt and decrypt block with offset b.
`timescale 1ns / 100ps

module tb_rabin_encrypt_decrypt;

  localparam int unsigned DataW = rabin_pkg::DataW;
  localparam int unsigned CfgIdxW = rabin_pkg::CfgIdxW;
  localparam int unsigned PrimeBits = 32;
  localparam int unsigned CycleLimit = 8000000;
  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;
  localparam logic [CfgIdxW-1:0] RegPrimeP = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPrimeQ = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKeyMod = 2'd2;
  localparam logic [CfgIdxW-1:0] RegOffsetB = 2'd3;

  typedef struct {
    logic             opcode;
    logic [DataW-1:0] data;
  } cipher_req_t;

  typedef struct {
    logic [DataW-1:0] value;
    logic [1:0]       index;
    logic             last;
  } cipher_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic opcode_i = 1'b0;
  logic [DataW-1:0] data_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [DataW-1:0] value_out_o;
  logic [1:0] candidate_index_o;
  logic last_o;

  // Key copy kept in step with the block's registers.
  logic [DataW-1:0] key_p, key_q, key_n, key_b;

  cipher_req_t pending_reqs[$];
  cipher_res_t expected_res[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  rabin_encrypt_decrypt #(.PRIME_BITS(PrimeBits)) u_dut (.*);

  always #5 clk_i = ~clk_i;

  // Modular arithmetic on wide products.
  function automatic logic [DataW-1:0] mulmod(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                              logic [DataW-1:0] m);
    logic [127:0] prod;
    prod = {64'd0, a % m} * {64'd0, b % m};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [DataW-1:0] addmod(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                              logic [DataW-1:0] m);
    logic [DataW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[DataW-1:0];
  endfunction

  function automatic logic [DataW-1:0] submod(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                              logic [DataW-1:0] m);
    return (a >= b) ? a - b : a + (m - b);
  endfunction

  function automatic logic [DataW-1:0] powmod(logic [DataW-1:0] base, logic [DataW-1:0] e,
                                              logic [DataW-1:0] m);
    logic [DataW-1:0] r;
    r = 64'd1 % m;
    base = base % m;
    while (e != 0) begin
      if (e[0]) r = mulmod(r, base, m);
      base = mulmod(base, base, m);
      e = e >> 1;
    end
    return r;
  endfunction

  // Extended Euclid: x*a + y*b = gcd(a, b).
  function automatic void euclid(input logic [DataW-1:0] a, input logic [DataW-1:0] b,
                                 output longint x, output longint y);
    longint x1, y1;
    if (a == 0) begin
      x = 0;
      y = 1;
    end else begin
      euclid(b % a, a, x1, y1);
      x = y1 - longint'(b / a) * x1;
      y = x1;
    end
  endfunction

  function automatic logic [DataW-1:0] signed_mod(longint v, logic [DataW-1:0] m);
    if (v >= 0) return 64'(v) % m;
    return submod(64'd0, 64'(-v) % m, m);
  endfunction

  function automatic logic [DataW-1:0] halve_mod(logic [DataW-1:0] v, logic [DataW-1:0] m);
    if (!v[0]) return v >> 1;
    return ((v >> 1) + (m >> 1) + {63'd0, m[0]}) % m;
  endfunction

  // Work out the results of one accepted transaction.
  function automatic void predict_cipher(cipher_req_t req);
    logic [DataW-1:0] nn, b, d, mp, mq, cp, cq, t1, t2, m, c;
    logic [DataW-1:0] roots[4];
    longint yp, yq;
    cipher_res_t res;
    if (req.opcode == OpEncrypt) begin
      c = '0;
      if (key_n != 0) begin
        m = req.data % key_n;
        c = mulmod(m, addmod(m, key_b % key_n, key_n), key_n);
      end
      res.value = c;
      res.index = 2'd0;
      res.last = 1'b1;
      expected_res.push_back(res);
      return;
    end
    if (key_p == 0 || key_q == 0) begin
      for (int k = 0; k < 4; k++) roots[k] = '0;
    end else begin
      nn = key_p * key_q;
      b = key_b % nn;
      d = addmod(mulmod(64'd4 % nn, req.data % nn, nn), mulmod(b, b, nn), nn);
      mp = powmod(d, (key_p + 1) / 4, key_p);
      mq = powmod(d, (key_q + 1) / 4, key_q);
      euclid(key_p, key_q, yp, yq);
      cp = mulmod(signed_mod(yp, nn), key_p % nn, nn);
      cq = mulmod(signed_mod(yq, nn), key_q % nn, nn);
      t1 = mulmod(cp, mq, nn);
      t2 = mulmod(cq, mp, nn);
      roots[0] = addmod(t1, t2, nn);
      roots[1] = submod(64'd0, roots[0], nn);
      roots[2] = submod(t1, t2, nn);
      roots[3] = submod(64'd0, roots[2], nn);
      for (int k = 0; k < 4; k++) roots[k] = halve_mod(submod(roots[k], b, nn), nn);
    end
    for (int k = 0; k < 4; k++) begin
      res.value = roots[k];
      res.index = 2'(k);
      res.last = (k == 3);
      expected_res.push_back(res);
    end
  endfunction

  // Input driver: bursts of transactions separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    cipher_req_t req;
    logic next_valid;
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_cipher('{opcode: opcode_i, data: data_in_i});
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs.pop_front();
          opcode_i <= req.opcode;
          data_in_i <= req.data;
          next_valid = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // Output monitor: compare each result transaction with the oldest expectation.
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    cipher_res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: value %h index %0d last %b",
                     value_out_o, candidate_index_o, last_o);
        end else begin
          want = expected_res.pop_front();
          if (value_out_o !== want.value || candidate_index_o !== want.index ||
              last_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %h/%0d/%b, got %h/%0d/%b", want.value,
                       want.index, want.last, value_out_o, candidate_index_o, last_o);
          end
        end
      end
      if ($urandom_range(0, 499) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) == 0);
        2: out_ready_i <= ($urandom_range(0, 9) == 0);
        default: out_ready_i <= (cycles % 7 < 3);
      endcase
    end
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_key(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    case (idx)
      RegPrimeP: key_p = value & ((64'd1 << PrimeBits) - 1) & 64'hFFFF_FFFF;
      RegPrimeQ: key_q = value & ((64'd1 << PrimeBits) - 1) & 64'hFFFF_FFFF;
      RegKeyMod: key_n = value;
      default: key_b = value;
    endcase
  endtask

  task automatic set_keys(logic [DataW-1:0] p, logic [DataW-1:0] q, logic [DataW-1:0] n,
                          logic [DataW-1:0] b);
    write_key(RegPrimeP, p);
    write_key(RegPrimeQ, q);
    write_key(RegKeyMod, n);
    write_key(RegOffsetB, b);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_req(logic op, logic [DataW-1:0] value);
    pending_reqs.push_back('{opcode: op, data: value});
  endtask

  task automatic queue_random(int unsigned count);
    logic [DataW-1:0] value;
    logic [DataW-1:0] modulus;
    for (int i = 0; i < count; i++) begin
      value = {$urandom, $urandom};
      modulus = (key_n != 0) ? key_n : 64'd1;
      if ($urandom_range(0, 2) != 0) value = value % modulus;
      queue_req($urandom_range(0, 1) ? OpDecrypt : OpEncrypt, value);
    end
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || in_valid_i || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  logic [DataW-1:0] rp, rq;

  initial begin
    key_p = 64'd3;
    key_q = 64'd7;
    key_n = 64'd21;
    key_b = 64'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset keys: field extremes and both operations.
    queue_req(OpEncrypt, 64'd0);
    queue_req(OpEncrypt, 64'd20);
    queue_req(OpEncrypt, '1);
    queue_req(OpDecrypt, 64'd0);
    queue_req(OpDecrypt, 64'd4);
    queue_req(OpDecrypt, '1);
    queue_random(8);
    drain();

    // Small proper key with an offset, input above the modulus.
    set_keys(64'd11, 64'd19, 64'd209, 64'd5);
    queue_req(OpEncrypt, 64'd300);
    queue_req(OpDecrypt, 64'd500);
    queue_random(14);
    drain();

    // Largest primes below 2^32 and the largest offset.
    set_keys(64'd4294967291, 64'd4294967279, 64'd4294967291 * 64'd4294967279, '1);
    queue_random(14);
    drain();

    // Zero prime for decrypt and zero modulus for encrypt.
    set_keys(64'd0, 64'd7, 64'd0, 64'd3);
    queue_random(10);
    drain();

    // Primes that share a factor, and a modulus that is not p times q.
    set_keys(64'd7, 64'd7, 64'd1000, 64'd0);
    queue_random(10);
    drain();

    // Even product, where odd values are halved with the modulus added.
    set_keys(64'd3, 64'd2, 64'd6, 64'd1);
    queue_random(10);
    drain();

    // All-ones keys; the masked primes are 3 mod 4 but not prime.
    set_keys('1, '1, '1, '1);
    queue_random(10);
    drain();

    // Random keys of the right form.
    for (int ph = 0; ph < 4; ph++) begin
      rp = {32'd0, $urandom} | 64'd3;
      rq = {32'd0, $urandom} | 64'd3;
      set_keys(rp, rq, rp * rq, {$urandom, $urandom});
      queue_random(12);
      drain();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
